FILE: design/rgbhr_pkg.sv
// rgbhr_pkg: shared constants and types for the rgb hue rotate pipeline
// no dependencies
package rgbhr_pkg;

    localparam int HUE_TURN     = 23040;
    localparam int HUE_SECTOR   = 3840;
    localparam int OFFSET_LIMIT = 5760;
    localparam int QUO_BITS     = 12;
    localparam int HUE_BITS     = 15;
    localparam int OFFSET_BITS  = 14;
    localparam int CFG_IDX_BITS = 8;
    localparam int RECIP_SHIFT  = 24;
    localparam int RECIP_15     = 1118481;
    localparam int RECIP_BITS   = 21;
    localparam int RAMP_BITS    = 12;

    typedef enum logic [1:0] {
        SEL_RED,
        SEL_GREEN,
        SEL_BLUE
    } t_sel;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_HUE_OFFSET = 8'd0,
        CFG_RGB_MODE   = 8'd1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        SEC_0,
        SEC_1,
        SEC_2,
        SEC_3,
        SEC_4,
        SEC_5
    } t_sector;

endpackage

FILE: design/rgbhr_analyze.sv
// rgbhr_analyze: max, min, chroma, hue channel select and divider numerator
// depends on rgbhr_pkg
module rgbhr_analyze #(
    parameter int CB = 12,
    parameter int AW = 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic [CB-1:0]         i_red,
    input  logic [CB-1:0]         i_green,
    input  logic [CB-1:0]         i_blue,
    input  logic [AW-1:0]         i_aux,
    output logic                  o_valid,
    output logic [CB+11:0]        o_num,
    output logic [CB-1:0]         o_chroma,
    output logic [CB-1:0]         o_min,
    output rgbhr_pkg::t_sel       o_sel,
    output logic                  o_neg,
    output logic [AW-1:0]         o_aux
);
    import rgbhr_pkg::*;

    logic [CB-1:0]   mx;
    logic [CB-1:0]   mn;
    logic signed [CB:0] diff;
    t_sel            sel;

    logic            r_va;
    logic [CB-1:0]   r_mn_a;
    logic [CB-1:0]   r_d_a;
    t_sel            r_sel_a;
    logic            r_neg_a;
    logic [CB-1:0]   r_abs_a;
    logic [AW-1:0]   r_aux_a;

    logic            r_vb;
    logic [CB+11:0]  r_num;
    logic [CB-1:0]   r_mn_b;
    logic [CB-1:0]   r_d_b;
    t_sel            r_sel_b;
    logic            r_neg_b;
    logic [AW-1:0]   r_aux_b;

    always_comb begin
        mx = i_red;
        mn = i_red;
        if (i_green > mx) mx = i_green;
        if (i_blue > mx) mx = i_blue;
        if (i_green < mn) mn = i_green;
        if (i_blue < mn) mn = i_blue;
        priority if (i_red == mx) begin
            sel  = SEL_RED;
            diff = $signed({1'b0, i_green}) - $signed({1'b0, i_blue});
        end else if (i_green == mx) begin
            sel  = SEL_GREEN;
            diff = $signed({1'b0, i_blue}) - $signed({1'b0, i_red});
        end else begin
            sel  = SEL_BLUE;
            diff = $signed({1'b0, i_red}) - $signed({1'b0, i_green});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else begin
            r_va <= i_valid;
            r_vb <= r_va;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mn_a  <= mn;
        r_d_a   <= mx - mn;
        r_sel_a <= sel;
        r_neg_a <= diff[CB];
        r_abs_a <= diff[CB] ? CB'(-diff) : diff[CB-1:0];
        r_aux_a <= i_aux;

        r_num   <= ({r_abs_a, 12'd0} - {4'd0, r_abs_a, 8'd0}) + (CB+12)'(r_d_a >> 1);
        r_mn_b  <= r_mn_a;
        r_d_b   <= r_d_a;
        r_sel_b <= r_sel_a;
        r_neg_b <= r_neg_a;
        r_aux_b <= r_aux_a;
    end

    assign o_valid  = r_vb;
    assign o_num    = r_num;
    assign o_chroma = r_d_b;
    assign o_min    = r_mn_b;
    assign o_sel    = r_sel_b;
    assign o_neg    = r_neg_b;
    assign o_aux    = r_aux_b;

endmodule

FILE: design/rgbhr_div_stage.sv
// rgbhr_div_stage: one registered restoring division step, one quotient bit
// depends on rgbhr_pkg
module rgbhr_div_stage #(
    parameter int NW   = 24,
    parameter int DW   = 12,
    parameter int STEP = 0,
    parameter int AW   = 1
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    input  logic [NW-1:0]                      i_rem,
    input  logic [DW-1:0]                      i_den,
    input  logic [rgbhr_pkg::QUO_BITS-1:0]     i_quo,
    input  logic [AW-1:0]                      i_aux,
    output logic                               o_valid,
    output logic [NW-1:0]                      o_rem,
    output logic [DW-1:0]                      o_den,
    output logic [rgbhr_pkg::QUO_BITS-1:0]     o_quo,
    output logic [AW-1:0]                      o_aux
);
    import rgbhr_pkg::*;

    logic [NW-1:0]       sub;
    logic                fits;
    logic [QUO_BITS-1:0] n_quo;
    logic                r_valid;
    logic [NW-1:0]       r_rem;
    logic [DW-1:0]       r_den;
    logic [QUO_BITS-1:0] r_quo;
    logic [AW-1:0]       r_aux;

    always_comb begin
        sub         = NW'(i_den) << STEP;
        fits        = (i_rem >= sub);
        n_quo       = i_quo;
        n_quo[STEP] = fits;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= fits ? (i_rem - sub) : i_rem;
        r_quo <= n_quo;
        r_den <= i_den;
        r_aux <= i_aux;
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_den   = r_den;
    assign o_quo   = r_quo;
    assign o_aux   = r_aux;

endmodule

FILE: design/rgbhr_rebuild.sv
// rgbhr_rebuild: hue offset and wrap, sector ramp and rgb reconstruction
// depends on rgbhr_pkg
module rgbhr_rebuild #(
    parameter int CB = 12
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    input  logic [rgbhr_pkg::QUO_BITS-1:0]       i_quo,
    input  logic [CB-1:0]                        i_chroma,
    input  logic [CB-1:0]                        i_min,
    input  rgbhr_pkg::t_sel                      i_sel,
    input  logic                                 i_neg,
    input  logic [CB-1:0]                        i_red,
    input  logic [CB-1:0]                        i_green,
    input  logic [CB-1:0]                        i_blue,
    input  logic                                 i_last,
    input  logic signed [rgbhr_pkg::OFFSET_BITS-1:0] i_offset,
    input  logic                                 i_mode,
    output logic                                 o_valid,
    output logic [CB-1:0]                        o_red,
    output logic [CB-1:0]                        o_green,
    output logic [CB-1:0]                        o_blue,
    output logic                                 o_last
);
    import rgbhr_pkg::*;

    localparam int NST = 6;
    localparam int PW  = CB + RAMP_BITS;
    localparam int WW  = CB + 5;
    localparam int MW  = WW + RECIP_BITS;

    logic [NST-1:0]       r_v;
    logic [CB-1:0]        r_d   [NST];
    logic [CB-1:0]        r_mn  [NST];
    logic [CB-1:0]        r_r   [NST];
    logic [CB-1:0]        r_g   [NST];
    logic [CB-1:0]        r_b   [NST];
    logic                 r_l   [NST];

    logic signed [16:0]   hue0;
    logic [HUE_BITS-1:0]  r_hue0;
    logic signed [OFFSET_BITS-1:0] offc;
    logic signed [16:0]   hsum;
    logic [HUE_BITS-1:0]  r_hue;
    t_sector              sec;
    logic [HUE_BITS-1:0]  sec_base;
    logic [RAMP_BITS-1:0] frac;
    t_sector              r_sec [2:NST-1];
    logic [RAMP_BITS-1:0] r_ramp;
    logic [PW-1:0]        r_prod;
    logic [PW:0]          rnd;
    logic [WW-1:0]        r_w;
    logic [MW-1:0]        r_mw;
    logic [WW-1:0]        q15;
    logic [WW-1:0]        rem15;
    logic [CB-1:0]        r_x;
    logic [CB-1:0]        c0;
    logic [CB-1:0]        c1;
    logic [CB-1:0]        c2;
    logic [CB-1:0]        dd;
    logic [CB-1:0]        xx;
    logic [CB-1:0]        r_ro;
    logic [CB-1:0]        r_go;
    logic [CB-1:0]        r_bo;
    logic                 r_lo;
    logic                 r_vo;

    // stage 0: signed quotient plus sector base
    always_comb begin
        logic signed [16:0] qs;
        qs = i_neg ? -$signed({5'd0, i_quo}) : $signed({5'd0, i_quo});
        unique case (i_sel)
            SEL_RED:   hue0 = (qs < 0) ? qs + 17'sd23040 : qs;
            SEL_GREEN: hue0 = qs + 17'sd7680;
            SEL_BLUE:  hue0 = qs + 17'sd15360;
            default:   hue0 = '0;
        endcase
        if (i_chroma == '0) hue0 = '0;
    end

    // stage 1: offset and wrap
    always_comb begin
        priority if (i_offset > OFFSET_BITS'(OFFSET_LIMIT))
            offc = OFFSET_BITS'(OFFSET_LIMIT);
        else if (i_offset < -OFFSET_BITS'(OFFSET_LIMIT))
            offc = -OFFSET_BITS'(OFFSET_LIMIT);
        else
            offc = i_offset;
        hsum = $signed({2'b00, r_hue0}) + $signed({{1{offc[OFFSET_BITS-1]}}, offc, 2'b00});
        priority if (hsum < 0)
            hsum = hsum + 17'sd23040;
        else if (hsum >= 17'sd23040)
            hsum = hsum - 17'sd23040;
    end

    // stage 2: sector and ramp
    always_comb begin
        priority if (r_hue >= HUE_BITS'(5 * HUE_SECTOR)) begin
            sec = SEC_5;
            sec_base = HUE_BITS'(5 * HUE_SECTOR);
        end else if (r_hue >= HUE_BITS'(4 * HUE_SECTOR)) begin
            sec = SEC_4;
            sec_base = HUE_BITS'(4 * HUE_SECTOR);
        end else if (r_hue >= HUE_BITS'(3 * HUE_SECTOR)) begin
            sec = SEC_3;
            sec_base = HUE_BITS'(3 * HUE_SECTOR);
        end else if (r_hue >= HUE_BITS'(2 * HUE_SECTOR)) begin
            sec = SEC_2;
            sec_base = HUE_BITS'(2 * HUE_SECTOR);
        end else if (r_hue >= HUE_BITS'(HUE_SECTOR)) begin
            sec = SEC_1;
            sec_base = HUE_BITS'(HUE_SECTOR);
        end else begin
            sec = SEC_0;
            sec_base = '0;
        end
        frac = RAMP_BITS'(r_hue - sec_base);
    end

    // stages 4 and 5: divide by 3840 as shift by 8 then reciprocal of 15
    always_comb begin
        rnd   = (PW+1)'(r_prod) + (PW+1)'(HUE_SECTOR / 2);
        q15   = WW'(r_mw >> RECIP_SHIFT);
        rem15 = r_w - WW'(q15 * 15);
    end

    // stage 6: place chroma and ramp by sector
    always_comb begin
        dd = r_d[NST-1];
        xx = r_x;
        c0 = '0;
        c1 = '0;
        c2 = '0;
        unique case (r_sec[NST-1])
            SEC_0: begin c0 = dd; c1 = xx; end
            SEC_1: begin c0 = xx; c1 = dd; end
            SEC_2: begin c1 = dd; c2 = xx; end
            SEC_3: begin c1 = xx; c2 = dd; end
            SEC_4: begin c0 = xx; c2 = dd; end
            default: begin c0 = dd; c2 = xx; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v  <= '0;
            r_vo <= 1'b0;
        end else begin
            r_v  <= {r_v[NST-2:0], i_valid};
            r_vo <= r_v[NST-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_d[0]  <= i_chroma;
        r_mn[0] <= i_min;
        r_r[0]  <= i_red;
        r_g[0]  <= i_green;
        r_b[0]  <= i_blue;
        r_l[0]  <= i_last;
        for (int k = 1; k < NST; k++) begin
            r_d[k]  <= r_d[k-1];
            r_mn[k] <= r_mn[k-1];
            r_r[k]  <= r_r[k-1];
            r_g[k]  <= r_g[k-1];
            r_b[k]  <= r_b[k-1];
            r_l[k]  <= r_l[k-1];
        end
        r_hue0   <= HUE_BITS'(hue0);
        r_hue    <= HUE_BITS'(hsum);
        r_sec[2] <= sec;
        r_ramp   <= sec[0] ? RAMP_BITS'(HUE_SECTOR) - frac : frac;
        for (int k = 3; k < NST; k++) begin
            r_sec[k] <= r_sec[k-1];
        end
        r_prod <= PW'(r_d[2]) * PW'(r_ramp);
        r_w    <= WW'(rnd >> 8);
        r_mw   <= MW'(WW'(rnd >> 8)) * MW'(RECIP_15);
        r_x    <= (rem15 >= WW'(15)) ? CB'(q15 + WW'(1)) : CB'(q15);
        r_ro   <= i_mode ? c0 + r_mn[NST-1] : r_r[NST-1];
        r_go   <= i_mode ? c1 + r_mn[NST-1] : r_g[NST-1];
        r_bo   <= i_mode ? c2 + r_mn[NST-1] : r_b[NST-1];
        r_lo   <= r_l[NST-1];
    end

    assign o_valid = r_vo;
    assign o_red   = r_ro;
    assign o_green = r_go;
    assign o_blue  = r_bo;
    assign o_last  = r_lo;

endmodule

FILE: design/rgb_hue_rotate.sv
// rgb_hue_rotate: hsv hue shift of one pixel per clock
// accepted start reaches o_valid through analyze, the hue divider and rebuild; throughput one pixel per cycle
// the 12-stage hue divider sets the depth; busy stays low
// synchronous active-low reset clears valid bits, hue_offset to 0 and rgb_mode to 1
// results cannot be stalled by the receiver
module rgb_hue_rotate #(
    parameter int CHANNEL_BITS = 12
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic [CHANNEL_BITS-1:0]                i_red_in,
    input  logic [CHANNEL_BITS-1:0]                i_green_in,
    input  logic [CHANNEL_BITS-1:0]                i_blue_in,
    input  logic                                   i_last_in,
    output logic                                   o_valid,
    output logic [CHANNEL_BITS-1:0]                o_red_out,
    output logic [CHANNEL_BITS-1:0]                o_green_out,
    output logic [CHANNEL_BITS-1:0]                o_blue_out,
    output logic                                   o_last_out,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [rgbhr_pkg::CFG_IDX_BITS-1:0]     i_cfg_index,
    input  logic [rgbhr_pkg::OFFSET_BITS-1:0]      i_cfg_data
);
    import rgbhr_pkg::*;

    localparam int CB  = CHANNEL_BITS;
    localparam int NW  = CB + 12;
    localparam int A1  = 3 * CB + 1;
    localparam int A2  = A1 + 2 * CB + 3;
    localparam int LAT = 2 + QUO_BITS + 7;

    logic signed [OFFSET_BITS-1:0] r_hue_offset;
    logic                          r_rgb_mode;

    logic                 an_valid;
    logic [NW-1:0]        an_num;
    logic [CB-1:0]        an_d;
    logic [CB-1:0]        an_mn;
    t_sel                 an_sel;
    logic                 an_neg;
    logic [A1-1:0]        an_aux;

    logic                 dv_valid [QUO_BITS+1];
    logic [NW-1:0]        dv_rem   [QUO_BITS+1];
    logic [CB-1:0]        dv_den   [QUO_BITS+1];
    logic [QUO_BITS-1:0]  dv_quo   [QUO_BITS+1];
    logic [A2-1:0]        dv_aux   [QUO_BITS+1];

    logic [A2-1:0]        fin;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hue_offset <= '0;
            r_rgb_mode   <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == CFG_HUE_OFFSET) r_hue_offset <= $signed(i_cfg_data);
            if (i_cfg_index == CFG_RGB_MODE) r_rgb_mode <= i_cfg_data[0];
        end
    end

    rgbhr_analyze #(.CB(CB), .AW(A1)) u_analyze (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (start && !busy),
        .i_red    (i_red_in),
        .i_green  (i_green_in),
        .i_blue   (i_blue_in),
        .i_aux    ({i_red_in, i_green_in, i_blue_in, i_last_in}),
        .o_valid  (an_valid),
        .o_num    (an_num),
        .o_chroma (an_d),
        .o_min    (an_mn),
        .o_sel    (an_sel),
        .o_neg    (an_neg),
        .o_aux    (an_aux)
    );

    assign dv_valid[0] = an_valid;
    assign dv_rem[0]   = an_num;
    assign dv_den[0]   = an_d;
    assign dv_quo[0]   = '0;
    assign dv_aux[0]   = {an_aux, an_mn, an_d, logic'(an_sel[1]), logic'(an_sel[0]), an_neg};

    for (genvar k = 0; k < QUO_BITS; k++) begin : g_div
        rgbhr_div_stage #(
            .NW   (NW),
            .DW   (CB),
            .STEP (QUO_BITS - 1 - k),
            .AW   (A2)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (dv_valid[k]),
            .i_rem   (dv_rem[k]),
            .i_den   (dv_den[k]),
            .i_quo   (dv_quo[k]),
            .i_aux   (dv_aux[k]),
            .o_valid (dv_valid[k+1]),
            .o_rem   (dv_rem[k+1]),
            .o_den   (dv_den[k+1]),
            .o_quo   (dv_quo[k+1]),
            .o_aux   (dv_aux[k+1])
        );
    end

    assign fin = dv_aux[QUO_BITS];

    rgbhr_rebuild #(.CB(CB)) u_rebuild (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (dv_valid[QUO_BITS]),
        .i_quo    (dv_quo[QUO_BITS]),
        .i_chroma (fin[CB+2:3]),
        .i_min    (fin[2*CB+2:CB+3]),
        .i_sel    (t_sel'(fin[2:1])),
        .i_neg    (fin[0]),
        .i_red    (fin[A2-1:A2-CB]),
        .i_green  (fin[A2-CB-1:A2-2*CB]),
        .i_blue   (fin[A2-2*CB-1:A2-3*CB]),
        .i_last   (fin[2*CB+3]),
        .i_offset (r_hue_offset),
        .i_mode   (r_rgb_mode),
        .o_valid  (o_valid),
        .o_red    (o_red_out),
        .o_green  (o_green_out),
        .o_blue   (o_blue_out),
        .o_last   (o_last_out)
    );

`ifndef SYNTHESIS
    a_latency : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, LAT))
        else $error("result without matching transaction");
    a_last : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_last_out == $past(i_last_in, LAT))
        else $error("last marker misaligned");
    a_div_valid : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dv_valid[QUO_BITS] |=> ##6 o_valid)
        else $error("result lost in rebuild stages");
`endif

endmodule
